[hw/rtl/pss_pkg.sv]
// ============================================================================
// Process slot scheduler package
// Shared types and constants for the process slot scheduler block.
// ============================================================================
package pss_pkg;

    localparam int DEF_NUM_SLOTS = 16;

    localparam int ACTION_W  = 3;
    localparam int TICKS_W   = 16;
    localparam int PID_BASE_W = 16;
    localparam int SLOT_W    = 4;
    localparam int PID_W     = 17;
    localparam int WAKENED_W = 5;
    localparam int RUN_W     = 32;

    // Raw action codes as they arrive on the input channel.
    localparam logic [ACTION_W-1:0] ACT_CREATE   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SCHEDULE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_BLOCK    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_EXIT     = 3'd4;

    // Slot status codes.
    typedef enum logic [1:0] {
        ST_DEAD    = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_BLOCKED = 2'd3
    } slot_status_t;

    // Decoded operation handed from the front end to the back end.
    typedef enum logic [2:0] {
        OP_CREATE,
        OP_TICK,
        OP_SCHEDULE,
        OP_BLOCK,
        OP_EXIT,
        OP_INVALID
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [TICKS_W-1:0] sleep_ticks;
    } cmd_t;

endpackage

[hw/rtl/pss_if.sv]
// ============================================================================
// Process slot scheduler channels
// Valid/ready channels for action transactions and result transactions.
// ============================================================================
interface pss_in_if
    import pss_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [TICKS_W-1:0]  sleep_ticks;

    modport source (output valid, output action, output sleep_ticks, input ready);
    modport sink   (input valid, input action, input sleep_ticks, output ready);
endinterface

interface pss_out_if
    import pss_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [SLOT_W-1:0]    slot;
    logic [PID_W-1:0]     pid;
    logic                 ok;
    logic                 idle;
    logic [WAKENED_W-1:0] wakened;
    logic [RUN_W-1:0]     run_time;

    modport source (output valid, output slot, output pid, output ok, output idle,
                    output wakened, output run_time, input ready);
    modport sink   (input valid, input slot, input pid, input ok, input idle,
                    input wakened, input run_time, output ready);
endinterface

[hw/rtl/pss_front.sv]
// ============================================================================
// Process slot scheduler front end
// Accepts action transactions, decodes them and holds them in a two-entry queue.
// ============================================================================
module pss_front
    import pss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pss_in_if.sink      in_ch,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_ready
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;
    cmd_t       dec;

    always_comb
    begin
        dec.sleep_ticks = in_ch.sleep_ticks;
        case (in_ch.action)
            ACT_CREATE:   dec.op = OP_CREATE;
            ACT_TICK:     dec.op = OP_TICK;
            ACT_SCHEDULE: dec.op = OP_SCHEDULE;
            ACT_BLOCK:    dec.op = OP_BLOCK;
            ACT_EXIT:     dec.op = OP_EXIT;
            default:      dec.op = OP_INVALID;
        endcase
    end

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign cmd_valid   = (cnt_reg != 2'd0);
    assign cmd         = q_reg[rd_ptr_reg];
    assign pop         = cmd_valid && cmd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

[hw/rtl/pss_back.sv]
// ============================================================================
// Process slot scheduler back end
// Holds the slot table and queues and carries out one decoded action at a time.
// ============================================================================
module pss_back
    import pss_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  cmd_t                  cmd,
    output logic                  cmd_ready,
    input  logic [PID_BASE_W-1:0] pid_base,
    pss_out_if.source             out_ch
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [CW-1:0] NSLOTS = CW'(NUM_SLOTS);

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_CREATE_SCAN,
        FSM_TICK_WALK,
        FSM_SCHED_POP
    } fsm_t;

    fsm_t               fsm_reg, fsm_next;
    slot_status_t       status_reg [NUM_SLOTS];
    logic [TICKS_W-1:0] sleep_left_reg [NUM_SLOTS];
    logic [SW-1:0]      ready_order_reg [NUM_SLOTS];
    logic [SW-1:0]      sleep_order_reg [NUM_SLOTS];
    logic [SW-1:0]      ready_head_reg, ready_head_next;
    logic [CW-1:0]      ready_count_reg, ready_count_next;
    logic [CW-1:0]      sleep_count_reg, sleep_count_next;
    logic [CW-1:0]      high_water_reg, high_water_next;
    logic [SW-1:0]      running_slot_reg, running_slot_next;
    logic               has_running_reg, has_running_next;
    logic [RUN_W-1:0]   running_time_reg, running_time_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      kept_reg, kept_next;
    logic [CW-1:0]      woke_reg, woke_next;

    logic                 out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]    out_slot_reg, out_slot_next;
    logic [PID_W-1:0]     out_pid_reg, out_pid_next;
    logic                 out_ok_reg, out_ok_next;
    logic                 out_idle_reg, out_idle_next;
    logic [WAKENED_W-1:0] out_woke_reg, out_woke_next;
    logic [RUN_W-1:0]     out_rt_reg, out_rt_next;

    // Single write port per table.
    logic               st_we;
    logic [SW-1:0]      st_addr;
    slot_status_t       st_data;
    logic               sl_we;
    logic [SW-1:0]      sl_addr;
    logic [TICKS_W-1:0] sl_data;
    logic               ro_we;
    logic [SW-1:0]      ro_addr;
    logic [SW-1:0]      ro_data;
    logic               so_we;
    logic [SW-1:0]      so_addr;
    logic [SW-1:0]      so_data;

    logic [CW:0]        tail_sum;
    logic [SW-1:0]      tail;
    logic [SW-1:0]      s;
    logic [TICKS_W-1:0] dec_left;
    logic [31:0]        woke_wide;
    logic [RUN_W-1:0]   cur_rt;

    assign tail_sum  = {1'b0, CW'(ready_head_reg)} + {1'b0, ready_count_reg};
    assign tail      = (tail_sum >= (CW+1)'(NUM_SLOTS)) ?
                       SW'(tail_sum - (CW+1)'(NUM_SLOTS)) : SW'(tail_sum);
    assign cur_rt    = has_running_reg ? running_time_reg : '0;
    assign woke_wide = 32'(woke_reg);
    assign cmd_ready = (fsm_reg == FSM_IDLE) && !out_valid_reg;

    function automatic logic [PID_W-1:0] make_pid(input logic [SW-1:0] sl,
                                                  input logic [PID_BASE_W-1:0] base);
        logic [31:0] sum;
        sum = 32'(sl) + 32'(base);
        return sum[PID_W-1:0];
    endfunction

    always_comb
    begin
        fsm_next          = fsm_reg;
        ready_head_next   = ready_head_reg;
        ready_count_next  = ready_count_reg;
        sleep_count_next  = sleep_count_reg;
        high_water_next   = high_water_reg;
        running_slot_next = running_slot_reg;
        has_running_next  = has_running_reg;
        running_time_next = running_time_reg;
        idx_next          = idx_reg;
        kept_next         = kept_reg;
        woke_next         = woke_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;
        out_slot_next     = out_slot_reg;
        out_pid_next      = out_pid_reg;
        out_ok_next       = out_ok_reg;
        out_idle_next     = out_idle_reg;
        out_woke_next     = out_woke_reg;
        out_rt_next       = out_rt_reg;
        st_we   = 1'b0;
        st_addr = '0;
        st_data = ST_DEAD;
        sl_we   = 1'b0;
        sl_addr = '0;
        sl_data = '0;
        ro_we   = 1'b0;
        ro_addr = tail;
        ro_data = '0;
        so_we   = 1'b0;
        so_addr = '0;
        so_data = '0;
        s        = '0;
        dec_left = '0;

        case (fsm_reg)
            FSM_IDLE:
            begin
                if (cmd_valid && cmd_ready)
                begin
                    idx_next      = '0;
                    kept_next     = '0;
                    woke_next     = '0;
                    out_slot_next = '0;
                    out_pid_next  = '0;
                    out_ok_next   = 1'b0;
                    out_idle_next = 1'b0;
                    out_woke_next = '0;
                    out_rt_next   = '0;
                    case (cmd.op)
                        OP_CREATE:
                        begin
                            fsm_next = FSM_CREATE_SCAN;
                        end
                        OP_TICK:
                        begin
                            if (has_running_reg)
                            begin
                                running_time_next = running_time_reg + 1'b1;
                            end
                            fsm_next = FSM_TICK_WALK;
                        end
                        OP_SCHEDULE:
                        begin
                            // Round robin: the running slot rejoins the tail first.
                            if (has_running_reg)
                            begin
                                has_running_next = 1'b0;
                                if (ready_count_reg < NSLOTS)
                                begin
                                    ro_we            = 1'b1;
                                    ro_data          = running_slot_reg;
                                    ready_count_next = ready_count_reg + 1'b1;
                                    st_we            = 1'b1;
                                    st_addr          = running_slot_reg;
                                    st_data          = ST_READY;
                                end
                            end
                            fsm_next = FSM_SCHED_POP;
                        end
                        OP_BLOCK, OP_EXIT:
                        begin
                            out_valid_next = 1'b1;
                            if (has_running_reg)
                            begin
                                out_slot_next     = SLOT_W'(running_slot_reg);
                                out_pid_next      = make_pid(running_slot_reg, pid_base);
                                out_ok_next       = 1'b1;
                                out_rt_next       = running_time_reg;
                                st_we             = 1'b1;
                                st_addr           = running_slot_reg;
                                sl_we             = 1'b1;
                                sl_addr           = running_slot_reg;
                                has_running_next  = 1'b0;
                                running_time_next = '0;
                                if (cmd.op == OP_BLOCK)
                                begin
                                    st_data = ST_BLOCKED;
                                    sl_data = cmd.sleep_ticks;
                                    if (sleep_count_reg < NSLOTS)
                                    begin
                                        so_we            = 1'b1;
                                        so_addr          = SW'(sleep_count_reg);
                                        so_data          = running_slot_reg;
                                        sleep_count_next = sleep_count_reg + 1'b1;
                                    end
                                end
                                else
                                begin
                                    st_data = ST_DEAD;
                                    sl_data = '0;
                                end
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            FSM_CREATE_SCAN:
            begin
                if (idx_reg < high_water_reg &&
                    status_reg[SW'(idx_reg)] != ST_DEAD)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    fsm_next       = FSM_IDLE;
                    out_valid_next = 1'b1;
                    out_rt_next    = cur_rt;
                    if (idx_reg >= high_water_reg && high_water_reg >= NSLOTS)
                    begin
                        out_ok_next = 1'b0;
                    end
                    else
                    begin
                        if (idx_reg >= high_water_reg)
                        begin
                            high_water_next = high_water_reg + 1'b1;
                        end
                        s             = SW'(idx_reg);
                        out_slot_next = SLOT_W'(s);
                        out_pid_next  = make_pid(s, pid_base);
                        out_ok_next   = 1'b1;
                        sl_we         = 1'b1;
                        sl_addr       = s;
                        sl_data       = '0;
                        if (ready_count_reg < NSLOTS)
                        begin
                            ro_we            = 1'b1;
                            ro_data          = s;
                            ready_count_next = ready_count_reg + 1'b1;
                            st_we            = 1'b1;
                            st_addr          = s;
                            st_data          = ST_READY;
                        end
                    end
                end
            end

            FSM_TICK_WALK:
            begin
                if (idx_reg < sleep_count_reg)
                begin
                    s        = sleep_order_reg[SW'(idx_reg)];
                    dec_left = (sleep_left_reg[s] == '0) ? '0 : sleep_left_reg[s] - 1'b1;
                    sl_we    = 1'b1;
                    sl_addr  = s;
                    sl_data  = dec_left;
                    idx_next = idx_reg + 1'b1;
                    if (dec_left == '0)
                    begin
                        woke_next = woke_reg + 1'b1;
                        if (ready_count_reg < NSLOTS)
                        begin
                            ro_we            = 1'b1;
                            ro_data          = s;
                            ready_count_next = ready_count_reg + 1'b1;
                            st_we            = 1'b1;
                            st_addr          = s;
                            st_data          = ST_READY;
                        end
                    end
                    else
                    begin
                        so_we     = 1'b1;
                        so_addr   = SW'(kept_reg);
                        so_data   = s;
                        kept_next = kept_reg + 1'b1;
                    end
                end
                else
                begin
                    sleep_count_next = kept_reg;
                    fsm_next         = FSM_IDLE;
                    out_valid_next   = 1'b1;
                    out_ok_next      = 1'b1;
                    out_woke_next    = woke_wide[WAKENED_W-1:0];
                    out_rt_next      = cur_rt;
                end
            end

            FSM_SCHED_POP:
            begin
                fsm_next          = FSM_IDLE;
                out_valid_next    = 1'b1;
                running_time_next = '0;
                if (ready_count_reg == '0)
                begin
                    out_idle_next = 1'b1;
                end
                else
                begin
                    s                 = ready_order_reg[ready_head_reg];
                    ready_head_next   = (ready_head_reg == SW'(NUM_SLOTS - 1)) ?
                                        '0 : ready_head_reg + 1'b1;
                    ready_count_next  = ready_count_reg - 1'b1;
                    st_we             = 1'b1;
                    st_addr           = s;
                    st_data           = ST_RUNNING;
                    sl_we             = 1'b1;
                    sl_addr           = s;
                    sl_data           = '0;
                    running_slot_next = s;
                    has_running_next  = 1'b1;
                    out_slot_next     = SLOT_W'(s);
                    out_pid_next      = make_pid(s, pid_base);
                    out_ok_next       = 1'b1;
                end
            end

            default:
            begin
                fsm_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ro_we)
        begin
            ready_order_reg[ro_addr] <= ro_data;
        end
        if (so_we)
        begin
            sleep_order_reg[so_addr] <= so_data;
        end
        out_slot_reg <= out_slot_next;
        out_pid_reg  <= out_pid_next;
        out_ok_reg   <= out_ok_next;
        out_idle_reg <= out_idle_next;
        out_woke_reg <= out_woke_next;
        out_rt_reg   <= out_rt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg          <= FSM_IDLE;
            ready_head_reg   <= '0;
            ready_count_reg  <= '0;
            sleep_count_reg  <= '0;
            high_water_reg   <= '0;
            running_slot_reg <= '0;
            has_running_reg  <= 1'b0;
            running_time_reg <= '0;
            idx_reg          <= '0;
            kept_reg         <= '0;
            woke_reg         <= '0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                status_reg[i]     <= ST_DEAD;
                sleep_left_reg[i] <= '0;
            end
        end
        else
        begin
            fsm_reg          <= fsm_next;
            ready_head_reg   <= ready_head_next;
            ready_count_reg  <= ready_count_next;
            sleep_count_reg  <= sleep_count_next;
            high_water_reg   <= high_water_next;
            running_slot_reg <= running_slot_next;
            has_running_reg  <= has_running_next;
            running_time_reg <= running_time_next;
            idx_reg          <= idx_next;
            kept_reg         <= kept_next;
            woke_reg         <= woke_next;
            out_valid_reg    <= out_valid_next;
            if (st_we)
            begin
                status_reg[st_addr] <= st_data;
            end
            if (sl_we)
            begin
                sleep_left_reg[sl_addr] <= sl_data;
            end
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.slot     = out_slot_reg;
    assign out_ch.pid      = out_pid_reg;
    assign out_ch.ok       = out_ok_reg;
    assign out_ch.idle     = out_idle_reg;
    assign out_ch.wakened  = out_woke_reg;
    assign out_ch.run_time = out_rt_reg;

endmodule

[hw/rtl/process_slot_scheduler.sv]
// ============================================================================
// Process slot scheduler
// Task scheduler over a fixed table of process slots with a round-robin ready
// queue and sleep timers.
// ============================================================================
// Each action transaction is accepted by a front end into a two-entry queue
// and carried out by a back end that owns the slot table, the ready queue and
// the list of sleepers; exactly one result transaction comes back per action.
// The back end works on one action at a time and walks its tables one entry
// per cycle. Block, exit and unknown actions register their result straight
// from the idle state; schedule passes through the pop state; create scans the
// slots up to the one it claims, or the whole table when it is full; tick
// walks the list of sleepers. The back end picks up the next action only once
// the previous result has left the output register.
// The pid_base register may be written only while no action is in flight.
module process_slot_scheduler
    import pss_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    pss_in_if.sink                in_ch,
    pss_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [PID_BASE_W-1:0] cfg_wdata
);

    // Base value added to a slot index to form the process identifier.
    logic [PID_BASE_W-1:0] pid_base_reg;

    // Decoded actions travel from the front end to the back end.
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pid_base_reg <= '0;
        end
        else if (cfg_we)
        begin
            pid_base_reg <= cfg_wdata;
        end
    end

    // The front end accepts and decodes transactions independently of the
    // back end, so its two-entry queue can fill while an action is executing.
    pss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    // The back end holds all scheduler state and the result register.
    pss_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .pid_base  (pid_base_reg),
        .out_ch    (out_ch)
    );

endmodule

[hw/rtl/pss_checker.sv]
// ============================================================================
// Process slot scheduler checker
// Port-level assertions on result transactions of the scheduler.
// ============================================================================
module pss_checker
    import pss_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [SLOT_W-1:0]    out_slot,
    input logic [PID_W-1:0]     out_pid,
    input logic                 out_ok,
    input logic                 out_idle,
    input logic [WAKENED_W-1:0] out_wakened,
    input logic [RUN_W-1:0]     out_run_time
);

    // A pending result stays until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped before it was taken");

    // A failed action names no slot and wakes no sleeper.
    a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ok |-> out_slot == '0 && out_pid == '0 && out_wakened == '0)
        else $error("failed action carries slot or wake data");

    // An idle schedule is never a success and leaves nothing running.
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_idle |-> !out_ok && out_run_time == '0)
        else $error("idle schedule reports success or run time");

    // Sleepers are only woken by a tick, which names no slot.
    a_wake_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_wakened != '0 |-> out_ok && out_slot == '0 && !out_idle)
        else $error("wakened count on a result that is not a tick");

endmodule

bind process_slot_scheduler pss_checker u_pss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_slot     (out_ch.slot),
    .out_pid      (out_ch.pid),
    .out_ok       (out_ch.ok),
    .out_idle     (out_ch.idle),
    .out_wakened  (out_ch.wakened),
    .out_run_time (out_ch.run_time)
);

[bench/tb_top.sv]
// ============================================================================
// Process slot scheduler testbench
// Drives action transactions with bursty gaps, stalls the result side, and
// checks every result transaction against a scheduler model kept here.
// ============================================================================
module tb_top;
    import pss_pkg::*;

    localparam int NSLOT = DEF_NUM_SLOTS;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [PID_BASE_W-1:0] cfg_wdata;

    pss_in_if  act_ch();
    pss_out_if res_ch();

    process_slot_scheduler #(.NUM_SLOTS(NSLOT)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(act_ch.sink),
        .out_ch(res_ch.source),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // One result transaction as the scheduler should produce it.
    typedef struct packed {
        logic [SLOT_W-1:0]    slot;
        logic [PID_W-1:0]     pid;
        logic                 ok;
        logic                 idle;
        logic [WAKENED_W-1:0] wakened;
        logic [RUN_W-1:0]     run_time;
    } sched_result_t;

    // Scheduler state mirrored by the testbench.
    slot_status_t        m_status[NSLOT];
    logic [15:0]         m_sleep[NSLOT];
    logic [3:0]          m_ready_q[NSLOT];
    int                  m_ready_head;
    int                  m_ready_cnt;
    logic [3:0]          m_sleepers[NSLOT];
    int                  m_sleep_cnt;
    int                  m_high_water;
    int                  m_run_slot;
    bit                  m_running;
    logic [RUN_W-1:0]    m_run_time;
    logic [PID_BASE_W-1:0] m_pid_base;

    sched_result_t pending_results[$];
    int  mismatch_count;
    int  checked_count;
    int  sent_count;
    int  idle_hits;
    int  full_hits;
    int  wake_hits;
    bit  stall_mode;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic model_reset();
        for (int i = 0; i < NSLOT; i++)
        begin
            m_status[i] = ST_DEAD;
            m_sleep[i] = '0;
            m_ready_q[i] = '0;
            m_sleepers[i] = '0;
        end
        m_ready_head = 0;
        m_ready_cnt = 0;
        m_sleep_cnt = 0;
        m_high_water = 0;
        m_run_slot = 0;
        m_running = 1'b0;
        m_run_time = '0;
        m_pid_base = '0;
    endtask

    // Appends a slot at the ready tail; a full queue drops the request.
    task automatic ready_push(input int s);
        int pos;
        if (m_ready_cnt >= NSLOT)
        begin
            return;
        end
        pos = (m_ready_head + m_ready_cnt) % NSLOT;
        m_ready_q[pos] = s[3:0];
        m_ready_cnt++;
        m_status[s] = ST_READY;
    endtask

    function automatic sched_result_t make_result(input int s, input bit ok, input bit idl,
                                                  input int woke, input logic [RUN_W-1:0] rt,
                                                  input bit with_slot);
        sched_result_t r;
        r.slot = with_slot ? s[3:0] : '0;
        r.pid = with_slot ? (PID_W'(s) + PID_W'(m_pid_base)) : '0;
        r.ok = ok;
        r.idle = idl;
        r.wakened = woke[WAKENED_W-1:0];
        r.run_time = rt;
        return r;
    endfunction

    // Applies one action to the mirrored state and returns its result.
    task automatic predict_action(input logic [ACTION_W-1:0] act, input logic [15:0] ticks,
                                  output sched_result_t r);
        int s;
        int kept;
        int woke;
        logic [RUN_W-1:0] rt;
        case (act)
            ACT_CREATE:
            begin
                s = 0;
                while (s < m_high_water && m_status[s] != ST_DEAD)
                begin
                    s++;
                end
                if (s >= m_high_water)
                begin
                    if (m_high_water >= NSLOT)
                    begin
                        full_hits++;
                        r = make_result(0, 0, 0, 0, m_running ? m_run_time : '0, 0);
                        return;
                    end
                    s = m_high_water;
                    m_high_water++;
                end
                m_sleep[s] = '0;
                ready_push(s);
                r = make_result(s, 1, 0, 0, m_running ? m_run_time : '0, 1);
            end
            ACT_TICK:
            begin
                if (m_running)
                begin
                    m_run_time++;
                end
                kept = 0;
                woke = 0;
                for (int i = 0; i < m_sleep_cnt; i++)
                begin
                    s = m_sleepers[i];
                    if (m_sleep[s] != 0)
                    begin
                        m_sleep[s]--;
                    end
                    if (m_sleep[s] == 0)
                    begin
                        ready_push(s);
                        woke++;
                    end
                    else
                    begin
                        m_sleepers[kept] = s[3:0];
                        kept++;
                    end
                end
                m_sleep_cnt = kept;
                if (woke > 0)
                begin
                    wake_hits++;
                end
                r = make_result(0, 1, 0, woke, m_running ? m_run_time : '0, 0);
            end
            ACT_SCHEDULE:
            begin
                if (m_running)
                begin
                    ready_push(m_run_slot);
                    m_running = 1'b0;
                end
                m_run_time = '0;
                if (m_ready_cnt == 0)
                begin
                    idle_hits++;
                    r = make_result(0, 0, 1, 0, '0, 0);
                    return;
                end
                s = m_ready_q[m_ready_head];
                m_ready_head = (m_ready_head + 1) % NSLOT;
                m_ready_cnt--;
                m_status[s] = ST_RUNNING;
                m_sleep[s] = '0;
                m_run_slot = s;
                m_running = 1'b1;
                r = make_result(s, 1, 0, 0, '0, 1);
            end
            ACT_BLOCK, ACT_EXIT:
            begin
                if (!m_running)
                begin
                    r = make_result(0, 0, 0, 0, '0, 0);
                    return;
                end
                s = m_run_slot;
                rt = m_run_time;
                if (act == ACT_BLOCK)
                begin
                    m_status[s] = ST_BLOCKED;
                    m_sleep[s] = ticks;
                    if (m_sleep_cnt < NSLOT)
                    begin
                        m_sleepers[m_sleep_cnt] = s[3:0];
                        m_sleep_cnt++;
                    end
                end
                else
                begin
                    m_status[s] = ST_DEAD;
                    m_sleep[s] = '0;
                end
                m_running = 1'b0;
                m_run_time = '0;
                r = make_result(s, 1, 0, 0, rt, 1);
            end
            default:
            begin
                r = make_result(0, 0, 0, 0, '0, 0);
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [RUN_W-1:0] got,
                                   input logic [RUN_W-1:0] want);
        mismatch_count++;
        $display("MISMATCH at result %0d: %s got %0h expected %0h",
                 checked_count, what, got, want);
    endtask

    // Sends one action transaction and records its expected result once accepted.
    task automatic send_action(input logic [ACTION_W-1:0] act, input logic [15:0] ticks);
        sched_result_t r;
        act_ch.valid <= 1'b1;
        act_ch.action <= act;
        act_ch.sleep_ticks <= ticks;
        @(posedge clk);
        while (!act_ch.ready)
        begin
            @(posedge clk);
        end
        predict_action(act, ticks, r);
        pending_results.push_back(r);
        sent_count++;
    endtask

    // Drops valid unless the next transaction follows immediately.
    task automatic send_gap(input int cycles);
        if (cycles > 0)
        begin
            act_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Waits for every expected result, then lets the block settle.
    task automatic drain();
        send_gap(1);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (NSLOT + 8) @(posedge clk);
    endtask

    task automatic write_pid_base(input logic [PID_BASE_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        m_pid_base = value;
        @(posedge clk);
    endtask

    // Result checker: compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", '0, '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_ch.slot !== want.slot)
                    report_mismatch("slot", res_ch.slot, want.slot);
                if (res_ch.pid !== want.pid)
                    report_mismatch("pid", res_ch.pid, want.pid);
                if (res_ch.ok !== want.ok)
                    report_mismatch("ok", res_ch.ok, want.ok);
                if (res_ch.idle !== want.idle)
                    report_mismatch("idle", res_ch.idle, want.idle);
                if (res_ch.wakened !== want.wakened)
                    report_mismatch("wakened", res_ch.wakened, want.wakened);
                if (res_ch.run_time !== want.run_time)
                    report_mismatch("run_time", res_ch.run_time, want.run_time);
            end
            checked_count++;
        end
    end

    // Receiver stall pattern: a shifting mask in stall mode, always ready otherwise.
    logic [7:0] stall_mask;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_mask <= 8'b1011_0110;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            stall_mask <= {stall_mask[6:0], stall_mask[7] ^ stall_mask[5] ^ 1'b1};
            res_ch.ready <= stall_mode ? (stall_mask[0] | ($urandom_range(0, 3) == 0)) : 1'b1;
        end
    end

    // Directed check of the corner cases: idle queue, no running slot, full table,
    // zero sleep, and unknown action codes.
    task automatic test_directed();
        send_action(ACT_SCHEDULE, 16'd0);
        send_action(ACT_BLOCK, 16'hFFFF);
        send_action(ACT_EXIT, 16'd0);
        send_action(3'd5, 16'hFFFF);
        send_action(3'd6, 16'h5555);
        send_action(3'd7, 16'hAAAA);
        for (int i = 0; i < NSLOT + 1; i++)
        begin
            send_action(ACT_CREATE, 16'd0);
        end
        send_action(ACT_SCHEDULE, 16'd0);
        send_action(ACT_TICK, 16'd0);
        send_action(ACT_BLOCK, 16'd0);
        send_action(ACT_TICK, 16'd0);
        send_action(ACT_SCHEDULE, 16'd0);
        send_action(ACT_EXIT, 16'd0);
        send_action(ACT_CREATE, 16'd0);
        drain();
    endtask

    // Random traffic biased toward well-formed lifecycles: create, schedule,
    // ticks, block or exit, with a share of noise and unknown codes.
    task automatic test_random(input int count, input bit long_sleeps);
        int burst;
        int pick;
        logic [ACTION_W-1:0] act;
        logic [15:0] ticks;
        int n;
        n = 0;
        while (n < count)
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && n < count; b++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    act = ACT_CREATE;
                else if (pick < 50)
                    act = ACT_TICK;
                else if (pick < 72)
                    act = ACT_SCHEDULE;
                else if (pick < 86)
                    act = ACT_BLOCK;
                else if (pick < 96)
                    act = ACT_EXIT;
                else
                    act = 3'($urandom_range(5, 7));
                if (long_sleeps && $urandom_range(0, 7) == 0)
                    ticks = 16'($urandom);
                else
                    ticks = 16'($urandom_range(0, 6));
                send_action(act, ticks);
                n++;
            end
            send_gap($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 20));
        end
        drain();
    endtask

    initial
    begin
        mismatch_count = 0;
        checked_count = 0;
        sent_count = 0;
        idle_hits = 0;
        full_hits = 0;
        wake_hits = 0;
        stall_mode = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        act_ch.valid = 1'b0;
        act_ch.action = '0;
        act_ch.sleep_ticks = '0;
        model_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_pid_base(16'hFFFF);
        stall_mode = 1'b1;
        test_random(350, 1'b0);
        write_pid_base(16'h0000);
        stall_mode = 1'b0;
        test_random(350, 1'b1);
        write_pid_base(16'($urandom));
        stall_mode = 1'b1;
        test_random(380, 1'b0);

        $display("Covered %0d actions and %0d results across three pid bases.",
                 sent_count, checked_count);
        $display("Idle schedules %0d, full-table creates %0d, ticks with wakeups %0d.",
                 idle_hits, full_hits, wake_hits);
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("process_slot_scheduler verification clean");
        end
        else
        begin
            $display("process_slot_scheduler verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial
    begin
        #3000000;
        $display("process_slot_scheduler verification failed");
        $finish;
    end

endmodule
